// ----- rtl/mia_pkg.sv -----
// Package for the adjugate matrix inverse block.
// Holds fixed formats, register indexes and the divider handshake types.
// Depends on nothing; the interface, top-level and divider files refer to it by scoped names.
package mia_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_SIZE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SING_THRESH = 2'd1;

  localparam int ACTIVE_SIZE_W = 3;
  localparam logic [ACTIVE_SIZE_W-1:0] ACTIVE_SIZE_RESET = 3'd4;
  localparam int THRESH_W = 32;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd42949673;

  // fixed point formats: entries Q.8, minors Q.32, results Q16.16
  localparam int DET_W      = 64;
  localparam int FRAC_BITS  = 8;
  localparam int LEAF_SHIFT = 24;
  localparam int OUT_SHIFT  = 16;
  localparam int OUT_W      = 32;
  localparam logic [DET_W-1:0] DET_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // divider: only the low 80 dividend bits can be nonzero
  localparam int DIV_STEPS    = DET_W + OUT_SHIFT;
  localparam int QUOT_CAP_BIT = 40;

  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_rsp_t;

endpackage

// ----- rtl/mia_if.sv -----
// Channel interfaces for the adjugate matrix inverse block.
// Input items, result items and configuration writes; uses mia_pkg.
interface mia_in_if #(parameter int ELEMENT_WIDTH = 16);
  logic                            valid;
  logic                            ready;
  logic signed [ELEMENT_WIDTH-1:0] element;
  logic                            last_element;
  modport source (output valid, element, last_element, input ready);
  modport sink   (input valid, element, last_element, output ready);
  modport mon    (input valid, ready, element, last_element);
endinterface

interface mia_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mia_pkg::OUT_W-1:0] inverse_element;
  logic                             singular;
  logic                             saturated;
  logic                             last_result;
  modport source (output valid, inverse_element, singular, saturated, last_result,
                  input ready);
  modport sink   (input valid, inverse_element, singular, saturated, last_result,
                  output ready);
  modport mon    (input valid, ready, inverse_element, singular, saturated, last_result);
endinterface

interface mia_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mia_pkg::CFG_INDEX_W-1:0]    index;
  logic [mia_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

// ----- rtl/matrix_inverse_adjugate.sv -----
// Top level of the adjugate matrix inverse block.
// Uses mia_pkg, the interfaces of mia_if.sv and mia_divider.
//
// Usage:
//   matrix : input entries, Q8.8, row-major; last_element starts the solve.
//   inverse: one Q16.16 result per inverse entry, row-major, last_result on
//            the final one; singular set (and entries zero) when the
//            determinant magnitude is below the threshold or zero.
//   cfg    : register writes (active_size, singular_threshold), always ready,
//            to be issued only while no solve is in progress.
// Loading accepts one entry per cycle. After the last entry the block computes
// the determinant by first-row cofactor expansion, multiplying each entry by
// its minor in two 32-bit halves and rounding the product before it is
// accumulated; unless the matrix is singular it then computes each cofactor
// the same way and divides it by the determinant with a restoring divide.
// matrix.ready is low for the whole solve.
// The result register holds an entry until taken; a stalled receiver stalls
// the solve at the next entry. Reset clears the load count, the registers to
// their defaults and any pending result; the matrix store is not cleared.
module matrix_inverse_adjugate #(
  parameter int MAX_SIZE      = 4,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  mia_in_if.sink      matrix,
  mia_out_if.source   inverse,
  mia_cfg_if.sink     cfg
);

  localparam int EW    = ELEMENT_WIDTH;
  localparam int K     = MAX_SIZE;
  localparam int DEPTH = K * K;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(K);
  localparam int SW    = $clog2(K + 1);
  localparam int DW    = mia_pkg::DET_W;
  localparam int PW    = 32 + EW;
  localparam int FW    = DW + EW + 1;
  localparam int OW    = mia_pkg::OUT_W;
  localparam logic [FW-1:0] ROUND = FW'(1) << (mia_pkg::FRAC_BITS - 1);
  localparam logic signed [DW:0] SUM_MAX = (DW+1)'(mia_pkg::DET_MAX);

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_ENTER = 4'd1;
  localparam logic [3:0] ST_PUSH  = 4'd2;
  localparam logic [3:0] ST_LEAF  = 4'd3;
  localparam logic [3:0] ST_RET   = 4'd4;
  localparam logic [3:0] ST_RDE   = 4'd5;
  localparam logic [3:0] ST_MUL1  = 4'd6;
  localparam logic [3:0] ST_MUL2  = 4'd7;
  localparam logic [3:0] ST_MUL3  = 4'd8;
  localparam logic [3:0] ST_ACC   = 4'd9;
  localparam logic [3:0] ST_CHECK = 4'd10;
  localparam logic [3:0] ST_COF   = 4'd11;
  localparam logic [3:0] ST_DIV   = 4'd12;
  localparam logic [3:0] ST_EMIT  = 4'd13;

  function automatic logic [CW-1:0] lowest_bit(input logic [K-1:0] m);
    logic [CW-1:0] r;
    logic          found;
    r     = '0;
    found = 1'b0;
    for (int i = 0; i < K; i++) begin
      if (m[i] && !found) begin
        r     = CW'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  // {found, index} of the lowest set bit above cur
  function automatic logic [CW:0] next_bit(input logic [K-1:0] m, input logic [CW-1:0] cur);
    logic [CW-1:0] r;
    logic          found;
    r     = '0;
    found = 1'b0;
    for (int i = 0; i < K; i++) begin
      if (m[i] && (i > int'(cur)) && !found) begin
        r     = CW'(i);
        found = 1'b1;
      end
    end
    return {found, r};
  endfunction

  function automatic logic [K-1:0] mask_of(input logic [SW-1:0] n);
    logic [K-1:0] m;
    m = '0;
    for (int i = 0; i < K; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

  function automatic logic [DW-1:0] mag64(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // registers
  logic [3:0]                   state;
  logic [mia_pkg::ACTIVE_SIZE_W-1:0] active_size;
  logic [mia_pkg::THRESH_W-1:0] thresh;
  logic [LW-1:0]                load_count;
  logic [SW-1:0]                n_solve;
  logic [SW-1:0]                k0;
  logic [CW-1:0]                d;
  logic                         mode_cof;
  logic [K-1:0]                 rows [K];
  logic [K-1:0]                 cols [K];
  logic [CW-1:0]                col  [K];
  logic signed [DW-1:0]         sum  [K];
  logic                         odd  [K];
  logic signed [DW-1:0]         ret_val;
  logic                         ret_neg;
  logic signed [DW-1:0]         det;
  logic                         singular;
  logic [CW-1:0]                x;
  logic [CW-1:0]                y;
  logic [DW-1:0]                md;
  logic [EW-1:0]                me_reg;
  logic                         mul_neg;
  logic [PW-1:0]                ph;
  logic [PW-1:0]                pl;
  logic signed [DW-1:0]         t_reg;
  logic [OW-1:0]                res_val;
  logic                         res_sat;
  logic                         out_valid;
  logic signed [OW-1:0]         out_elem;
  logic                         out_sing;
  logic                         out_sat;
  logic                         out_last;
  logic signed [EW-1:0]         mem [DEPTH];
  logic signed [EW-1:0]         rd_data;

  // combinational helpers
  logic [SW-1:0]        n_eff;
  logic [LW-1:0]        nn_eff;
  logic                 load_acc;
  logic                 load_wr;
  logic [CW-1:0]        row_lo;
  logic [CW-1:0]        cmask_lo;
  logic [CW-1:0]        rd_col;
  logic [AW-1:0]        rd_addr;
  logic                 leaf;
  logic [EW-1:0]        me_comb;
  logic [FW-1:0]        full;
  logic [FW-1:0]        shifted;
  logic [DW-1:0]        t_mag;
  logic signed [DW-1:0] addend;
  logic signed [DW:0]   s65;
  logic signed [DW-1:0] sum_new;
  logic [CW:0]          nb;
  logic [K-1:0]         all_solve;
  logic                 sing_now;
  logic                 pos_last;
  logic                 y_wrap;
  logic [CW-1:0]        nx;
  logic [CW-1:0]        ny;
  logic [CW-1:0]        setup_x;
  logic [CW-1:0]        setup_y;
  logic [K-1:0]         cof_rows;
  logic [K-1:0]         cof_cols;
  logic signed [DW-1:0] cof_val;
  logic                 emit_ok;
  mia_pkg::div_req_t    div_req;
  mia_pkg::div_rsp_t    div_rsp;
  logic [OW-1:0]        div_quot;

  // clamp active size into the supported range
  always_comb begin
    if (active_size < mia_pkg::ACTIVE_SIZE_W'(2)) begin
      n_eff = SW'(2);
    end else if (active_size > mia_pkg::ACTIVE_SIZE_W'(K)) begin
      n_eff = SW'(K);
    end else begin
      n_eff = SW'(active_size);
    end
    nn_eff = LW'(int'(n_eff) * int'(n_eff));
  end

  assign matrix.ready = (state == ST_LOAD);
  assign cfg.ready    = 1'b1;
  assign load_acc     = matrix.valid && matrix.ready;
  assign load_wr      = load_acc && (load_count < nn_eff);

  // store addressing for the current recursion level
  always_comb begin
    row_lo   = lowest_bit(rows[d]);
    cmask_lo = lowest_bit(cols[d]);
    rd_col   = (state == ST_ENTER) ? cmask_lo : col[d];
    rd_addr  = AW'(int'(row_lo) * int'(n_solve) + int'(rd_col));
    leaf     = (SW'(d) + SW'(1) == k0);
  end

  // matrix store
  always_ff @(posedge clk) begin
    if (load_wr) begin
      mem[load_count[AW-1:0]] <= matrix.element;
    end
    rd_data <= mem[rd_addr];
  end

  // product of entry and minor, rounded to 32 fraction bits, saturated
  always_comb begin
    me_comb = rd_data[EW-1] ? EW'(-rd_data) : EW'(rd_data);
    full    = (FW'(ph) << 32) + FW'(pl) + ROUND;
    shifted = full >> mia_pkg::FRAC_BITS;
    t_mag   = (|shifted[FW-1:DW-1]) ? mia_pkg::DET_MAX : DW'(shifted[DW-2:0]);
  end

  // saturating accumulation and next column
  always_comb begin
    addend = odd[d] ? -t_reg : t_reg;
    s65    = (DW+1)'(sum[d]) + (DW+1)'(addend);
    if (s65 > SUM_MAX) begin
      sum_new = DW'(SUM_MAX);
    end else if (s65 < -SUM_MAX) begin
      sum_new = DW'(-SUM_MAX);
    end else begin
      sum_new = DW'(s65);
    end
    nb = next_bit(cols[d], col[d]);
  end

  // cofactor sequencing
  always_comb begin
    all_solve = mask_of(n_solve);
    sing_now  = (det == '0) || (mag64(det) < DW'(thresh));
    y_wrap    = (SW'(y) == n_solve - SW'(1));
    pos_last  = y_wrap && (SW'(x) == n_solve - SW'(1));
    ny        = y_wrap ? '0 : y + CW'(1);
    nx        = y_wrap ? x + CW'(1) : x;
    setup_x   = (state == ST_CHECK) ? '0 : nx;
    setup_y   = (state == ST_CHECK) ? '0 : ny;
    cof_rows  = all_solve & ~(K'(1) << setup_y);
    cof_cols  = all_solve & ~(K'(1) << setup_x);
    cof_val   = (x[0] ^ y[0]) ? -ret_val : ret_val;
    emit_ok   = !out_valid || inverse.ready;
  end

  assign div_req.start = (state == ST_COF);
  assign div_req.neg   = cof_val[DW-1] ^ det[DW-1];

  mia_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .num  (mag64(cof_val)),
    .den  (mag64(det)),
    .rsp  (div_rsp),
    .quot (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= mia_pkg::ACTIVE_SIZE_RESET;
      thresh      <= mia_pkg::THRESH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        mia_pkg::REG_ACTIVE_SIZE: active_size <= cfg.data[mia_pkg::ACTIVE_SIZE_W-1:0];
        mia_pkg::REG_SING_THRESH: thresh      <= cfg.data[mia_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      det        <= '0;
      out_valid  <= 1'b0;
    end else begin
      // a taken result clears here unless the emit step reloads it
      if (out_valid && inverse.ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (load_acc) begin
            if (matrix.last_element) begin
              load_count <= '0;
              n_solve    <= n_eff;
              k0         <= n_eff;
              rows[0]    <= mask_of(n_eff);
              cols[0]    <= mask_of(n_eff);
              d          <= '0;
              mode_cof   <= 1'b0;
              state      <= ST_ENTER;
            end else if (load_wr) begin
              load_count <= load_count + LW'(1);
            end
          end
        end
        ST_ENTER: begin
          if (leaf) begin
            state <= ST_LEAF;
          end else begin
            sum[d] <= '0;
            odd[d] <= 1'b0;
            col[d] <= cmask_lo;
            state  <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          rows[CW'(d + CW'(1))] <= rows[d] & ~(K'(1) << row_lo);
          cols[CW'(d + CW'(1))] <= cols[d] & ~(K'(1) << col[d]);
          d     <= d + CW'(1);
          state <= ST_ENTER;
        end
        ST_LEAF: begin
          ret_val <= {{(DW-EW){rd_data[EW-1]}}, rd_data} <<< mia_pkg::LEAF_SHIFT;
          state   <= ST_RET;
        end
        ST_RET: begin
          if (d == '0) begin
            if (mode_cof) begin
              state <= ST_COF;
            end else begin
              det   <= ret_val;
              state <= ST_CHECK;
            end
          end else begin
            d       <= d - CW'(1);
            md      <= mag64(ret_val);
            ret_neg <= ret_val[DW-1];
            state   <= ST_RDE;
          end
        end
        ST_RDE: begin
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          ph      <= PW'(md[DW-1:32]) * PW'(me_comb);
          me_reg  <= me_comb;
          mul_neg <= rd_data[EW-1] ^ ret_neg;
          state   <= ST_MUL2;
        end
        ST_MUL2: begin
          pl    <= PW'(md[31:0]) * PW'(me_reg);
          state <= ST_MUL3;
        end
        ST_MUL3: begin
          t_reg <= mul_neg ? -$signed(t_mag) : $signed(t_mag);
          state <= ST_ACC;
        end
        ST_ACC: begin
          sum[d] <= sum_new;
          odd[d] <= ~odd[d];
          if (nb[CW]) begin
            col[d] <= nb[CW-1:0];
            state  <= ST_PUSH;
          end else begin
            ret_val <= sum_new;
            state   <= ST_RET;
          end
        end
        ST_CHECK: begin
          singular <= sing_now;
          x        <= '0;
          y        <= '0;
          if (sing_now) begin
            state <= ST_EMIT;
          end else begin
            rows[0]  <= cof_rows;
            cols[0]  <= cof_cols;
            k0       <= n_solve - SW'(1);
            d        <= '0;
            mode_cof <= 1'b1;
            state    <= ST_ENTER;
          end
        end
        ST_COF: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            res_val <= div_quot;
            res_sat <= div_rsp.sat;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid <= 1'b1;
            out_elem  <= singular ? '0 : $signed(res_val);
            out_sing  <= singular;
            out_sat   <= singular ? 1'b0 : res_sat;
            out_last  <= pos_last;
            if (pos_last) begin
              state <= ST_LOAD;
            end else begin
              x <= nx;
              y <= ny;
              if (!singular) begin
                rows[0] <= cof_rows;
                cols[0] <= cof_cols;
                d       <= '0;
                state   <= ST_ENTER;
              end
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign inverse.valid           = out_valid;
  assign inverse.inverse_element = out_elem;
  assign inverse.singular        = out_sing;
  assign inverse.saturated       = out_sat;
  assign inverse.last_result     = out_last;

endmodule

// ----- rtl/mia_divider.sv -----
// Restoring divider: (num << 16) / den, one quotient bit per cycle.
// Quotient truncates toward zero and saturates to 32 signed bits; uses mia_pkg.
module mia_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  mia_pkg::div_req_t           req,
  input  logic [mia_pkg::DET_W-1:0]   num,
  input  logic [mia_pkg::DET_W-1:0]   den,
  output mia_pkg::div_rsp_t           rsp,
  output logic [mia_pkg::OUT_W-1:0]   quot
);

  localparam int DW    = mia_pkg::DET_W;
  localparam int DVD_W = mia_pkg::DIV_STEPS;
  localparam int CNT_W = $clog2(mia_pkg::DIV_STEPS + 1);
  localparam int Q_W   = mia_pkg::QUOT_CAP_BIT + 1;
  localparam int OW    = mia_pkg::OUT_W;
  localparam logic [Q_W:0] Q_CAP = (Q_W+1)'(1) << mia_pkg::QUOT_CAP_BIT;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DW-1:0]    rem;
  logic [Q_W-1:0]   q;
  logic             big;
  logic             neg;

  logic [DW-1:0]    rem_step;
  logic [Q_W:0]     q_step;
  logic             big_step;
  logic [OW-1:0]    lim;
  logic             over;
  logic [OW-1:0]    qv;

  // one shift and compare step
  always_comb begin
    rem_step = {rem[DW-2:0], dvd[DVD_W-1]};
    q_step   = {q, 1'b0};
    big_step = big;
    if (rem_step >= den) begin
      rem_step  = rem_step - den;
      q_step[0] = 1'b1;
    end
    if (q_step >= Q_CAP) begin
      q_step   = Q_CAP;
      big_step = 1'b1;
    end
  end

  // saturate and apply sign
  always_comb begin
    lim  = neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    over = big || (q > Q_W'(lim));
    qv   = over ? lim : q[OW-1:0];
  end

  assign quot     = neg ? (-qv) : qv;
  assign rsp.done = done;
  assign rsp.sat  = over;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(mia_pkg::DIV_STEPS);
        dvd  <= {num, {mia_pkg::OUT_SHIFT{1'b0}}};
        rem  <= '0;
        q    <= '0;
        big  <= 1'b0;
        neg  <= req.neg;
      end else if (busy) begin
        dvd <= {dvd[DVD_W-2:0], 1'b0};
        rem <= rem_step;
        q   <= q_step[Q_W-1:0];
        big <= big_step;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/mia_checker.sv -----
// Port-level checks for matrix_inverse_adjugate, attached by bind.
// Watches the input and result channels; depends on nothing else.
module mia_checker (
  input logic        clk,
  input logic        rst,
  input logic        matrix_valid,
  input logic        matrix_ready,
  input logic        matrix_last,
  input logic        inverse_valid,
  input logic        inverse_ready,
  input logic [31:0] inverse_element,
  input logic        inverse_singular,
  input logic        inverse_saturated,
  input logic        inverse_last
);

  // a final entry starts a solve: no more entries next cycle
  a_solve_blocks_input: assert property (@(posedge clk) disable iff (rst)
    matrix_valid && matrix_ready && matrix_last |=> !matrix_ready)
    else $error("input accepted right after the final entry");

  // while a non-final result is pending the solve is still running
  a_busy_during_results: assert property (@(posedge clk) disable iff (rst)
    inverse_valid && !inverse_last |-> !matrix_ready)
    else $error("input ready before the last result");

  // singular results are zero and never clipped
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    inverse_valid && inverse_singular |->
      (inverse_element == 32'h0) && !inverse_saturated)
    else $error("singular result not zero");

  // a clipped entry sits at one end of the range
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    inverse_valid && inverse_saturated |->
      (inverse_element == 32'h7FFF_FFFF) ||
      (inverse_element == 32'h8000_0000))
    else $error("saturated entry not at range limit");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    inverse_valid && !inverse_ready |=>
      inverse_valid && $stable(inverse_element) && $stable(inverse_last))
    else $error("stalled result changed");

endmodule

bind matrix_inverse_adjugate mia_checker u_mia_checker (
  .clk               (clk),
  .rst               (rst),
  .matrix_valid      (matrix.valid),
  .matrix_ready      (matrix.ready),
  .matrix_last       (matrix.last_element),
  .inverse_valid     (inverse.valid),
  .inverse_ready     (inverse.ready),
  .inverse_element   (inverse.inverse_element),
  .inverse_singular  (inverse.singular),
  .inverse_saturated (inverse.saturated),
  .inverse_last      (inverse.last_result)
);
